[rtl/mcps_pkg.sv]
// ----------------------------------------------------------------------------
// mcps_pkg: shared constants for the pulse scheduler
// Request codes, result codes and the wrapping time compare.
// ----------------------------------------------------------------------------
package mcps_pkg;

  localparam int unsigned DefChannels  = 8;
  localparam int unsigned DefMaxPulses = 4;
  localparam logic [31:0] ResetNow     = 32'd1000000;
  localparam int unsigned NumRegs      = 8;
  localparam int unsigned RegIdxW      = 3;
  localparam int unsigned RegW         = 16;

  // request codes
  localparam logic [1:0] KindAdvance  = 2'd0;
  localparam logic [1:0] KindSchedule = 2'd1;
  localparam logic [1:0] KindSeq      = 2'd2;
  localparam logic [1:0] KindCancel   = 2'd3;

  // result codes
  localparam logic [1:0] ResEdge    = 2'd0;
  localparam logic [1:0] ResNoEdge  = 2'd1;
  localparam logic [1:0] ResAnswer  = 2'd2;
  localparam logic [1:0] ResCancel  = 2'd3;

  // a is after b when a - b, read signed, is positive
  function automatic logic later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

[rtl/multi_channel_pulse_scheduler.sv]
// ----------------------------------------------------------------------------
// multi_channel_pulse_scheduler
// Output-compare pulse scheduler, one request at a time.
// ----------------------------------------------------------------------------
// A request is taken only when in_ready_o is high. Schedule, cancel and
// non-last sequence requests give their result through S_OUT. For a last
// sequence element the staged pulses are checked one per cycle, then
// copied to memory one per cycle. An advance scans the channels one per
// cycle through one shared compare unit. Each fired edge goes through
// scan, fire and emit (S_LOAD and S_LOAD2 come between fire and emit
// when a falling edge reloads a queued pulse). The advance ends with a
// final scan and fire, and output stalls can hold it in emit. An edge
// result is held back until the next scan shows whether it is the last
// one. Sequence pulses live in a small memory read one entry per cycle
// after a falling edge. No clearing pass is needed after reset.
module multi_channel_pulse_scheduler import mcps_pkg::*; #(
  parameter int unsigned CHANNELS   = DefChannels,
  parameter int unsigned MAX_PULSES = DefMaxPulses
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RegIdxW-1:0]   cfg_idx_i,
  input  logic [RegW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  logic [3:0]           channel_i,
  input  logic [31:0]          target_time_i,
  input  logic [31:0]          on_time_i,
  input  logic [31:0]          off_time_i,
  input  logic                 last_pulse_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           result_kind_o,
  output logic                 accepted_o,
  output logic [2:0]           edge_channel_o,
  output logic                 edge_rising_o,
  output logic [31:0]          edge_time_o,
  output logic [31:0]          now_time_o,
  output logic [7:0]           active_mask_o,
  output logic                 last_result_o
);

  localparam int unsigned ChW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PW   = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
  localparam int unsigned CntW = $clog2(MAX_PULSES + 1);
  localparam int unsigned SeqD = CHANNELS * MAX_PULSES;
  localparam int unsigned SaW  = (SeqD > 1) ? $clog2(SeqD) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SEQCHK, S_SCAN, S_FIRE, S_LOAD, S_LOAD2, S_EMIT, S_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [RegW-1:0] recharge_q [NumRegs];

  // channel state
  logic [CHANNELS-1:0] armed_q, active_q;
  logic [31:0]         rise_q [CHANNELS];
  logic [31:0]         fall_q [CHANNELS];
  logic [CntW-1:0]     cnt_q  [CHANNELS];
  logic [CntW-1:0]     idx_q  [CHANNELS];
  logic [31:0]         now_q;

  // staging buffer
  logic [31:0]     stg_on_q  [MAX_PULSES];
  logic [31:0]     stg_off_q [MAX_PULSES];
  logic [CntW-1:0] stg_cnt_q;
  logic            stg_err_q;

  // sequence memory
  logic [31:0] seq_on_mem  [SeqD];
  logic [31:0] seq_off_mem [SeqD];
  logic [31:0] rd_on_q, rd_off_q;
  logic        mem_we;
  logic [SaW-1:0] mem_waddr, mem_raddr;

  // request latched
  logic [ChW-1:0]  ch_q;
  logic [31:0]     tgt_q;
  logic [CntW-1:0] n_q;       // pulses in sequence under check
  logic [PW-1:0]   i_q;       // check pointer
  logic            ok_q;

  // scan
  logic [ChW-1:0] scan_q, best_ch_q;
  logic           found_q, best_rise_q;
  logic [31:0]    best_q;
  logic [6:0]     nres_q;

  // output register
  logic [1:0]  rk_q;
  logic        acc_q, er_q, last_q, ov_q;
  logic [2:0]  ech_q;
  logic [31:0] et_q, nt_q;
  logic [7:0]  mask_q;

  logic [7:0] mask;
  always_comb begin
    mask = '0;
    mask[CHANNELS-1:0] = active_q;
  end

  // held edge must not be delivered before it knows whether it is last
  logic hold_edge;
  assign hold_edge = ov_q && ((state_q == S_SCAN) || (state_q == S_FIRE));

  assign in_ready_o     = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o    = ov_q && !hold_edge;
  assign result_kind_o  = rk_q;
  assign accepted_o     = acc_q;
  assign edge_channel_o = ech_q;
  assign edge_rising_o  = er_q;
  assign edge_time_o    = et_q;
  assign now_time_o     = nt_q;
  assign active_mask_o  = mask_q;
  assign last_result_o  = last_q;

  // shared compare unit: candidate for scanned channel
  logic        c_rise_ok, c_fall_ok, c_better_r, c_better_f;
  logic [31:0] c_rise, c_fall;
  always_comb begin
    c_rise    = rise_q[scan_q];
    c_fall    = fall_q[scan_q];
    c_rise_ok = armed_q[scan_q] && !active_q[scan_q] && !later(c_rise, tgt_q)
                && later(c_rise, now_q);
    c_fall_ok = active_q[scan_q] && !later(c_fall, tgt_q) && later(c_fall, now_q);
    c_better_r = !found_q || later(best_q, c_rise);
    c_better_f = c_fall_ok && (!(found_q || c_rise_ok) ||
                 later(c_rise_ok && c_better_r ? c_rise : best_q, c_fall));
  end

  // sequence check for element i_q
  logic [31:0] gap;
  logic        chk_bad;
  always_comb begin
    gap = stg_on_q[i_q] - stg_off_q[i_q - PW'(1)];
    chk_bad = !later(stg_off_q[i_q], stg_on_q[i_q]);
    if (i_q != '0) begin
      if (!later(stg_on_q[i_q], stg_off_q[i_q - PW'(1)])) chk_bad = 1'b1;
      if (gap < {16'd0, recharge_q[RegIdxW'(ch_q)]}) chk_bad = 1'b1;
    end
  end

  // sequence memory ports
  always_comb begin
    mem_we    = (state_q == S_SEQCHK) && ok_q && (i_q == PW'(n_q - CntW'(1)))
                && !chk_bad && later(stg_on_q[0], now_q);
    mem_waddr = SaW'(ch_q * MAX_PULSES);
    mem_raddr = SaW'(best_ch_q * MAX_PULSES + idx_q[best_ch_q]);
  end

  // memory writes of a whole accepted sequence go through copy steps below
  logic [PW-1:0] cp_q;
  logic          cp_act_q;
  always_ff @(posedge clk_i) begin
    if (cp_act_q) begin
      seq_on_mem[mem_waddr + SaW'(cp_q)]  <= stg_on_q[cp_q];
      seq_off_mem[mem_waddr + SaW'(cp_q)] <= stg_off_q[cp_q];
    end
    rd_on_q  <= seq_on_mem[mem_raddr];
    rd_off_q <= seq_off_mem[mem_raddr];
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      armed_q   <= '0;
      active_q  <= '0;
      now_q     <= ResetNow;
      stg_cnt_q <= '0;
      stg_err_q <= 1'b0;
      ov_q      <= 1'b0;
      cp_act_q  <= 1'b0;
      cp_q      <= '0;
      nres_q    <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        rise_q[c] <= '0;
        fall_q[c] <= '0;
        cnt_q[c]  <= '0;
        idx_q[c]  <= '0;
      end
      for (int r = 0; r < NumRegs; r++) recharge_q[r] <= '0;
    end else begin
      if (cfg_we_i) recharge_q[cfg_idx_i] <= cfg_data_i;
      if (out_valid_o && out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !ov_q) begin
            ch_q  <= ChW'(channel_i);
            tgt_q <= target_time_i;
            rk_q  <= ResAnswer;
            acc_q <= 1'b0;
            ech_q <= '0;
            er_q  <= 1'b0;
            et_q  <= '0;
            nt_q  <= now_q;
            last_q <= 1'b1;
            case (kind_i)
              KindAdvance: begin
                scan_q  <= '0;
                found_q <= 1'b0;
                nres_q  <= '0;
                state_q <= S_SCAN;
              end
              KindSchedule: begin
                if (channel_i < CHANNELS) begin
                  if (active_q[channel_i[ChW-1:0]]) begin
                    fall_q[channel_i[ChW-1:0]] <= off_time_i;
                    acc_q <= 1'b1;
                  end else if (later(on_time_i, now_q)) begin
                    armed_q[channel_i[ChW-1:0]] <= 1'b1;
                    rise_q[channel_i[ChW-1:0]]  <= on_time_i;
                    fall_q[channel_i[ChW-1:0]]  <= off_time_i;
                    acc_q <= 1'b1;
                  end
                end
                state_q <= S_OUT;
              end
              KindSeq: begin
                state_q <= S_OUT;
                if (!last_pulse_i) begin
                  if (stg_cnt_q >= CntW'(MAX_PULSES)) stg_err_q <= 1'b1;
                  else begin
                    stg_on_q[stg_cnt_q[PW-1:0]]  <= on_time_i;
                    stg_off_q[stg_cnt_q[PW-1:0]] <= off_time_i;
                    stg_cnt_q <= stg_cnt_q + CntW'(1);
                    acc_q <= !stg_err_q;
                  end
                end else begin
                  stg_cnt_q <= '0;
                  stg_err_q <= 1'b0;
                  if (!stg_err_q && stg_cnt_q < CntW'(MAX_PULSES)) begin
                    stg_on_q[stg_cnt_q[PW-1:0]]  <= on_time_i;
                    stg_off_q[stg_cnt_q[PW-1:0]] <= off_time_i;
                    n_q  <= stg_cnt_q + CntW'(1);
                    i_q  <= '0;
                    ok_q <= (channel_i < CHANNELS) && !active_q[channel_i[ChW-1:0]];
                    state_q <= S_SEQCHK;
                  end
                end
              end
              default: begin
                rk_q <= ResCancel;
                if (channel_i < CHANNELS) begin
                  armed_q[channel_i[ChW-1:0]]  <= 1'b0;
                  active_q[channel_i[ChW-1:0]] <= 1'b0;
                  cnt_q[channel_i[ChW-1:0]]    <= '0;
                  idx_q[channel_i[ChW-1:0]]    <= '0;
                  acc_q <= 1'b1;
                end
                state_q <= S_OUT;
              end
            endcase
          end
        end
        // one staged pulse checked per cycle, then copied to memory
        S_SEQCHK: begin
          if (cp_act_q) begin
            if (cp_q == PW'(n_q - CntW'(1))) begin
              cp_act_q <= 1'b0;
              state_q  <= S_OUT;
            end else cp_q <= cp_q + PW'(1);
          end else if (!ok_q || chk_bad) begin
            state_q <= S_OUT;
          end else if (i_q == PW'(n_q - CntW'(1))) begin
            if (mem_we) begin
              acc_q <= 1'b1;
              rise_q[ch_q]  <= stg_on_q[0];
              fall_q[ch_q]  <= stg_off_q[0];
              armed_q[ch_q] <= 1'b1;
              cnt_q[ch_q]   <= n_q;
              idx_q[ch_q]   <= CntW'(1);
              cp_act_q <= 1'b1;
              cp_q     <= '0;
            end else state_q <= S_OUT;
          end else i_q <= i_q + PW'(1);
        end
        // one channel per cycle through the compare unit
        S_SCAN: begin
          if (c_better_f) begin
            found_q <= 1'b1; best_q <= c_fall; best_ch_q <= scan_q; best_rise_q <= 1'b0;
          end else if (c_rise_ok && c_better_r) begin
            found_q <= 1'b1; best_q <= c_rise; best_ch_q <= scan_q; best_rise_q <= 1'b1;
          end
          if (scan_q == ChW'(CHANNELS - 1)) state_q <= S_FIRE;
          else scan_q <= scan_q + ChW'(1);
        end
        S_FIRE: begin
          if (!found_q || nres_q == 7'd64) begin
            now_q <= tgt_q;
            if (nres_q == '0) begin
              rk_q <= ResNoEdge; acc_q <= 1'b0; nt_q <= tgt_q; last_q <= 1'b1;
              mask_q <= mask;
              ov_q <= 1'b1;
            end
            state_q <= S_IDLE;
          end else begin
            now_q <= best_q;
            if (best_rise_q) begin
              active_q[best_ch_q] <= 1'b1;
              state_q <= S_EMIT;
            end else begin
              active_q[best_ch_q] <= 1'b0;
              if (idx_q[best_ch_q] < cnt_q[best_ch_q]) state_q <= S_LOAD;
              else begin
                armed_q[best_ch_q] <= 1'b0;
                cnt_q[best_ch_q] <= '0;
                idx_q[best_ch_q] <= '0;
                state_q <= S_EMIT;
              end
            end
          end
        end
        S_LOAD: state_q <= S_LOAD2;
        S_LOAD2: begin
          rise_q[best_ch_q]  <= rd_on_q;
          fall_q[best_ch_q]  <= rd_off_q;
          idx_q[best_ch_q]   <= idx_q[best_ch_q] + CntW'(1);
          armed_q[best_ch_q] <= 1'b1;
          state_q <= S_EMIT;
        end
        // hold result until previous one drained; peek next to mark last
        S_EMIT: begin
          if (!ov_q || out_ready_i) begin
            rk_q   <= ResEdge;
            acc_q  <= 1'b0;
            ech_q  <= 3'(best_ch_q);
            er_q   <= best_rise_q;
            et_q   <= best_q;
            nt_q   <= best_q;
            mask_q <= mask;
            last_q <= 1'b0;
            ov_q   <= 1'b1;
            nres_q <= nres_q + 7'd1;
            scan_q  <= '0;
            found_q <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        default: begin
          // S_OUT: single answer
          if (!ov_q || out_ready_i) begin
            nt_q   <= now_q;
            mask_q <= mask;
            ov_q   <= 1'b1;
            state_q <= S_IDLE;
          end
        end
      endcase
      // an advance that ends with edges retags its held last edge
      if (state_q == S_FIRE && (!found_q || nres_q == 7'd64) && nres_q != '0) begin
        last_q <= 1'b1;
        nt_q   <= tgt_q;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("took a request while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q & ~armed_q) == '0)
    else $error("channel high without armed pulse");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= 7'd64)
    else $error("too many edges in one advance");

endmodule

[bench/multi_channel_pulse_scheduler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_channel_pulse_scheduler_tb
// Self-checking bench: a directed table, then random schedule, sequence,
// cancel and advance requests, with random stalls on both sides. Every
// result is checked against a local predictor of the scheduler.
// ----------------------------------------------------------------------------
module multi_channel_pulse_scheduler_tb import mcps_pkg::*; ();

  localparam int unsigned NCH    = 8;
  localparam int unsigned NPULSE = 4;
  localparam int unsigned MAXRES = 64;
  localparam int unsigned LIMIT  = 400000;
  localparam int unsigned NRAND  = 195;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  ch;
    logic [31:0] tt;
    logic [31:0] on_t;
    logic [31:0] off_t;
    logic        last;
    logic        typed;
    logic [1:0]  xkind;
    logic        xacc;
  } stim_t;

  typedef struct packed {
    logic [1:0]  rk;
    logic        acc;
    logic [2:0]  ch;
    logic        rising;
    logic [31:0] etime;
    logic [31:0] now_t;
    logic [7:0]  mask;
    logic        last;
  } res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        kind_i = KindAdvance;
  logic [3:0]        channel_i = '0;
  logic [31:0]       target_time_i = '0;
  logic [31:0]       on_time_i = '0;
  logic [31:0]       off_time_i = '0;
  logic              last_pulse_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        result_kind_o;
  logic              accepted_o;
  logic [2:0]        edge_channel_o;
  logic              edge_rising_o;
  logic [31:0]       edge_time_o;
  logic [31:0]       now_time_o;
  logic [7:0]        active_mask_o;
  logic              last_result_o;

  multi_channel_pulse_scheduler u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .kind_i, .channel_i, .target_time_i,
    .on_time_i, .off_time_i, .last_pulse_i,
    .out_valid_o, .out_ready_i, .result_kind_o, .accepted_o, .edge_channel_o,
    .edge_rising_o, .edge_time_o, .now_time_o, .active_mask_o, .last_result_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] now_p;
  logic [NCH-1:0] armed_p, high_p;
  logic [31:0] rise_p [NCH];
  logic [31:0] fall_p [NCH];
  logic [31:0] qon_p [NCH][NPULSE];
  logic [31:0] qoff_p [NCH][NPULSE];
  int unsigned qcnt_p [NCH];
  int unsigned qidx_p [NCH];
  int unsigned stg_n;
  logic        stg_err;
  logic [31:0] stg_on [NPULSE];
  logic [31:0] stg_off [NPULSE];
  logic [15:0] gap_min [NCH];

  res_t expected_q [$];
  int unsigned errors = 0, n_sent = 0, n_results = 0, n_edges = 0, n_seq_ok = 0;
  int unsigned cycles = 0;
  logic quiet = 1'b0;

  function automatic logic is_after(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 0) && !d[31];
  endfunction

  function automatic res_t mk_res(logic [1:0] rk, logic acc, logic [2:0] ch, logic rising,
                                  logic [31:0] et, logic [31:0] nt, logic last);
    res_t r;
    r.rk = rk; r.acc = acc; r.ch = ch; r.rising = rising; r.etime = et;
    r.now_t = nt; r.mask = high_p; r.last = last;
    return r;
  endfunction

  // fire the edges in (now, t] in order, at most MAXRES, lower channel on ties
  task automatic run_to(logic [31:0] t);
    int n, nx;
    logic [31:0] best;
    logic rising;
    n = 0;
    while (n < MAXRES) begin
      nx = -1; best = '0; rising = 1'b0;
      for (int c = 0; c < NCH; c++) begin
        if (armed_p[c] && !high_p[c] && !is_after(rise_p[c], t) && is_after(rise_p[c], now_p))
          if (nx < 0 || is_after(best, rise_p[c])) begin
            nx = c; best = rise_p[c]; rising = 1'b1;
          end
        if (high_p[c] && !is_after(fall_p[c], t) && is_after(fall_p[c], now_p))
          if (nx < 0 || is_after(best, fall_p[c])) begin
            nx = c; best = fall_p[c]; rising = 1'b0;
          end
      end
      if (nx < 0) break;
      now_p = best;
      if (rising) begin
        high_p[nx] = 1'b1;
      end else begin
        high_p[nx] = 1'b0;
        // reload the next queued pulse, if any
        if (qidx_p[nx] < qcnt_p[nx] && qidx_p[nx] < NPULSE) begin
          rise_p[nx] = qon_p[nx][qidx_p[nx]];
          fall_p[nx] = qoff_p[nx][qidx_p[nx]];
          qidx_p[nx]++;
          armed_p[nx] = 1'b1;
        end else begin
          armed_p[nx] = 1'b0;
          qcnt_p[nx] = 0;
          qidx_p[nx] = 0;
        end
      end
      expected_q.push_back(mk_res(ResEdge, 1'b0, nx[2:0], rising, best, best, 1'b0));
      n++;
    end
    now_p = t;
    if (n == 0) begin
      expected_q.push_back(mk_res(ResNoEdge, 1'b0, '0, 1'b0, '0, t, 1'b1));
    end else begin
      expected_q[$].now_t = t;
      expected_q[$].last = 1'b1;
    end
  endtask

  function automatic logic seq_fits(logic [3:0] ch, int unsigned n);
    if (ch >= NCH || n == 0 || n > NPULSE || high_p[ch[2:0]]) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!is_after(stg_off[i], stg_on[i])) return 1'b0;
      if (i > 0) begin
        if (!is_after(stg_on[i], stg_off[i-1])) return 1'b0;
        if (stg_on[i] - stg_off[i-1] < {16'd0, gap_min[ch[2:0]]}) return 1'b0;
      end
    end
    return is_after(stg_on[0], now_p);
  endfunction

  task automatic predict_req(stim_t s);
    logic ok;
    logic [2:0] c;
    ok = 1'b0;
    c = s.ch[2:0];
    case (s.kind)
      KindAdvance: run_to(s.tt);
      KindSchedule: begin
        if (s.ch < NCH) begin
          if (high_p[c]) begin
            fall_p[c] = s.off_t; ok = 1'b1;
          end else if (is_after(s.on_t, now_p)) begin
            armed_p[c] = 1'b1; rise_p[c] = s.on_t; fall_p[c] = s.off_t; ok = 1'b1;
          end
        end
        expected_q.push_back(mk_res(ResAnswer, ok, '0, 1'b0, '0, now_p, 1'b1));
      end
      KindSeq: begin
        if (!s.last) begin
          if (stg_n >= NPULSE) begin
            stg_err = 1'b1;
          end else begin
            stg_on[stg_n] = s.on_t; stg_off[stg_n] = s.off_t; stg_n++;
            ok = !stg_err;
          end
        end else begin
          if (!stg_err && stg_n < NPULSE) begin
            stg_on[stg_n] = s.on_t; stg_off[stg_n] = s.off_t;
            ok = seq_fits(s.ch, stg_n + 1);
            if (ok) begin
              rise_p[c] = stg_on[0]; fall_p[c] = stg_off[0]; armed_p[c] = 1'b1;
              qcnt_p[c] = stg_n + 1; qidx_p[c] = 1;
              for (int i = 0; i <= stg_n; i++) begin
                qon_p[c][i] = stg_on[i]; qoff_p[c][i] = stg_off[i];
              end
              n_seq_ok++;
            end
          end
          stg_n = 0; stg_err = 1'b0;
        end
        expected_q.push_back(mk_res(ResAnswer, ok, '0, 1'b0, '0, now_p, 1'b1));
      end
      default: begin
        if (s.ch < NCH) begin
          armed_p[c] = 1'b0; high_p[c] = 1'b0; qcnt_p[c] = 0; qidx_p[c] = 0; ok = 1'b1;
        end
        expected_q.push_back(mk_res(ResCancel, ok, '0, 1'b0, '0, now_p, 1'b1));
      end
    endcase
  endtask

  task automatic report_mismatch(string what, res_t got, res_t exp_r);
    errors++;
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, exp_r, n_results);
  endtask

  // result side: check on accept, then pick the next stall
  always @(posedge clk_i) begin
    res_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{result_kind_o, accepted_o, edge_channel_o, edge_rising_o, edge_time_o,
              now_time_o, active_mask_o, last_result_o};
      n_results++;
      if (got.rk == ResEdge) n_edges++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", got, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.rk !== want.rk || got.acc !== want.acc || got.ch !== want.ch ||
            got.rising !== want.rising || got.etime !== want.etime ||
            got.now_t !== want.now_t || got.mask !== want.mask || got.last !== want.last)
          report_mismatch("field", got, want);
      end
    end
    out_ready_i <= quiet || ($urandom_range(0, 99) >= 19);
  end

  // run limit
  always @(posedge clk_i) begin
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[multi_channel_pulse_scheduler] ERROR");
      $finish;
    end
  end

  // drive one request and predict on accept
  task automatic send_req(stim_t s);
    if (!quiet && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= s.kind; channel_i <= s.ch; target_time_i <= s.tt;
    on_time_i <= s.on_t; off_time_i <= s.off_t; last_pulse_i <= s.last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_req(s);
    if (s.typed) begin
      expected_q[$].rk = s.xkind;
      expected_q[$].acc = s.xacc;
    end
    n_sent++;
  endtask

  // hold off until every result is back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_gaps(logic [15:0] v [NCH]);
    for (int i = 0; i < NCH; i++) begin
      cfg_we_i <= 1'b1; cfg_idx_i <= i[RegIdxW-1:0]; cfg_data_i <= v[i];
      @(posedge clk_i);
      gap_min[i] = v[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic stim_t req(logic [1:0] k, logic [3:0] ch, logic [31:0] tt,
                                logic [31:0] on_t, logic [31:0] off_t, logic last);
    stim_t s;
    s = '{k, ch, tt, on_t, off_t, last, 1'b0, 2'd0, 1'b0};
    return s;
  endfunction

  // one well-formed sequence, now and then with a broken time
  task automatic send_sequence();
    int unsigned n;
    logic [3:0] ch;
    logic [31:0] t;
    stim_t s;
    n = $urandom_range(1, NPULSE);
    ch = $urandom_range(0, 99) < 8 ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
    t = now_p + $urandom_range(1, 600);
    for (int i = 0; i < n; i++) begin
      if (i > 0) t = t + gap_min[ch[2:0]] + $urandom_range(1, 200);
      s = req(KindSeq, (i == n - 1) ? ch : 4'($urandom), '0, t, '0, i == n - 1);
      t = t + $urandom_range(1, 300);
      s.off_t = t;
      if ($urandom_range(0, 99) < 6) s.on_t = $urandom;
      if ($urandom_range(0, 99) < 6) s.off_t = $urandom;
      send_req(s);
    end
    // occasionally overflow the staging buffer
    if ($urandom_range(0, 99) < 5) begin
      for (int i = 0; i <= NPULSE; i++) send_req(req(KindSeq, 4'($urandom), '0, $urandom,
                                                     $urandom, 1'b0));
      send_req(req(KindSeq, ch, '0, $urandom, $urandom, 1'b1));
    end
  endtask

  task automatic send_random();
    int unsigned pick;
    stim_t s;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_sequence();
    end else if (pick < 55) begin
      s = req(KindSchedule, 4'($urandom_range(0, 9)), $urandom, '0, '0, 1'($urandom));
      s.on_t = now_p + $urandom_range(1, 800);
      s.off_t = s.on_t + $urandom_range(1, 500);
      if ($urandom_range(0, 9) == 0) begin
        s.on_t = $urandom; s.off_t = $urandom;
      end
      send_req(s);
    end else if (pick < 85) begin
      s = req(KindAdvance, 4'($urandom), '0, $urandom, $urandom, 1'($urandom));
      case ($urandom_range(0, 9))
        0: s.tt = $urandom;
        1, 2: s.tt = now_p + $urandom_range(0, 140000);
        default: s.tt = now_p + $urandom_range(0, 1500);
      endcase
      send_req(s);
    end else if (pick < 95) begin
      send_req(req(KindCancel, 4'($urandom), $urandom, $urandom, $urandom, 1'($urandom)));
    end else begin
      send_req(req(2'($urandom), 4'($urandom), $urandom, $urandom, $urandom, 1'($urandom)));
    end
  endtask

  stim_t dir_tbl [25];
  logic [15:0] gaps [NCH];

  initial begin
    now_p = ResetNow; armed_p = '0; high_p = '0; stg_n = 0; stg_err = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      rise_p[c] = '0; fall_p[c] = '0; qcnt_p[c] = 0; qidx_p[c] = 0; gap_min[c] = '0;
    end
    for (int i = 0; i < NPULSE; i++) begin
      stg_on[i] = '0; stg_off[i] = '0;
    end

    // kind, channel, target, on, off, last, typed, typed kind, typed accept
    dir_tbl = '{
      '{KindAdvance,  4'd0,  32'd1000000, 32'd0, 32'd0, 1'b0, 1'b1, ResNoEdge, 1'b0},
      '{KindSchedule, 4'd15, 32'd0, 32'd1000100, 32'd1000200, 1'b0, 1'b1, ResAnswer, 1'b0},
      '{KindSchedule, 4'd0,  32'd0, 32'd1000000, 32'd1000200, 1'b0, 1'b1, ResAnswer, 1'b0},
      '{KindSchedule, 4'd0,  32'd0, 32'd1000100, 32'd1000300, 1'b0, 1'b1, ResAnswer, 1'b1},
      '{KindSchedule, 4'd7,  32'd0, 32'd1000100, 32'd1000150, 1'b0, 1'b1, ResAnswer, 1'b1},
      '{KindAdvance,  4'd9,  32'd1000120, 32'd0, 32'd0, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSchedule, 4'd0,  32'd0, 32'd5, 32'd1000400, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd0,  32'd0, 32'd1000500, 32'd1000600, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd0,  32'd0, 32'd1000700, 32'd1000800, 1'b1, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd3,  32'd0, 32'd1000200, 32'd1000250, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd3,  32'd0, 32'd1000300, 32'd1000350, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd3,  32'd0, 32'd1000400, 32'd1000450, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd1,  32'd0, 32'd1000500, 32'd1000550, 1'b1, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd2,  32'd0, 32'd1001000, 32'd1001010, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd2,  32'd0, 32'd1001020, 32'd1001030, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd2,  32'd0, 32'd1001040, 32'd1001050, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd2,  32'd0, 32'd1001060, 32'd1001070, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd2,  32'd0, 32'd1001080, 32'd1001090, 1'b0, 1'b1, ResAnswer, 1'b0},
      '{KindSeq,      4'd2,  32'd0, 32'd1001100, 32'd1001110, 1'b1, 1'b1, ResAnswer, 1'b0},
      '{KindCancel,   4'd15, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, ResCancel, 1'b0},
      '{KindCancel,   4'd7,  32'd0, 32'd0, 32'd0, 1'b0, 1'b1, ResCancel, 1'b1},
      '{KindAdvance,  4'd0,  32'd1002000, 32'd0, 32'd0, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindAdvance,  4'd0,  32'hFFFFFFFF, 32'd0, 32'd0, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSchedule, 4'd3,  32'd0, 32'd0, 32'hFFFFFFFF, 1'b0, 1'b0, ResEdge, 1'b0},
      '{KindSeq,      4'd8,  32'd0, 32'd100, 32'd200, 1'b1, 1'b1, ResAnswer, 1'b0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) send_req(dir_tbl[i]);
    drain();

    // three gap settings: small random, extremes, wide random
    for (int ph = 0; ph < 3; ph++) begin
      for (int c = 0; c < NCH; c++) begin
        case (ph)
          0: gaps[c] = 16'($urandom_range(0, 50));
          1: gaps[c] = c[0] ? 16'hFFFF : 16'h0000;
          default: gaps[c] = 16'($urandom);
        endcase
      end
      write_gaps(gaps);
      while (n_sent < 25 + (ph + 1) * NRAND / 3) begin
        quiet = (ph == 1) && (n_sent < 25 + NRAND / 3 + 40);
        send_random();
      end
      quiet = 1'b0;
      drain();
    end

    $display("covered %0d requests, %0d results (%0d edges), %0d sequences loaded",
             n_sent, n_results, n_edges, n_seq_ok);
    if (errors == 0) begin
      $display("[multi_channel_pulse_scheduler] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[multi_channel_pulse_scheduler] ERROR");
    end
    $finish;
  end

endmodule
